/* hw/rtl/pcfd_pkg.sv */
// ----------------------------------------------------------------------------
// pcfd_pkg
// Shared types and constants for the PWM command frame decoder.
// ----------------------------------------------------------------------------
package pcfd_pkg;

    localparam int unsigned FRAME_LEN = 8;
    localparam int unsigned POS_W     = $clog2(FRAME_LEN);
    localparam int unsigned HDR_BYTES = 4;

    localparam logic [7:0] CHAR_CR = 8'd13;

    // Command letters
    localparam logic [7:0] CMD_BIMORPH = 8'h42; // 'B'
    localparam logic [7:0] CMD_MIRROR  = 8'h4D; // 'M'
    localparam logic [7:0] CMD_LASER   = 8'h4C; // 'L'
    localparam logic [7:0] CMD_P       = 8'h50;
    localparam logic [7:0] CMD_U       = 8'h55;
    localparam logic [7:0] CMD_D       = 8'h44;
    localparam logic [7:0] CMD_R       = 8'h52;
    localparam logic [7:0] CMD_V       = 8'h56;
    localparam logic [7:0] CMD_G       = 8'h47;
    localparam logic [7:0] CMD_H       = 8'h48;
    localparam logic [7:0] CMD_K       = 8'h4B;
    localparam logic [7:0] CMD_E       = 8'h45;
    localparam logic [7:0] CMD_F       = 8'h46;
    localparam logic [7:0] CMD_O       = 8'h4F;

    // Bimorph channel address range
    localparam logic [7:0] BIMORPH_ADDR_FIRST = 8'd1;
    localparam logic [7:0] BIMORPH_ADDR_LAST  = 8'd4;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_UNKNOWN = 2'd1,
        STATUS_FRAMING = 2'd2
    } status_t;

    localparam logic [2:0] TARGET_NONE   = 3'd0;
    localparam logic [2:0] TARGET_MIRROR = 3'd5;
    localparam logic [2:0] TARGET_LASER  = 3'd6;

    // Completed frame handed from capture to decode
    typedef struct packed {
        logic [7:0]  letter;
        logic [7:0]  addr;
        logic [15:0] pulse;
        logic        term_ok;
    } frame_t;

endpackage

/* hw/rtl/pcfd_frame_capture.sv */
// ----------------------------------------------------------------------------
// pcfd_frame_capture
// Byte position counter, header byte store and completed-frame register.
// ----------------------------------------------------------------------------
module pcfd_frame_capture
    import pcfd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       rx_valid,
    output logic       rx_ready,
    input  logic [7:0] rx_byte,
    output logic       frame_valid,
    input  logic       frame_ready,
    output frame_t     frame
);

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LEN - 1);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       hdr_reg [HDR_BYTES];
    logic             frame_valid_reg, frame_valid_next;
    frame_t           frame_reg;
    logic             rx_beat;
    logic             last_byte;

    assign last_byte = (pos_reg == LAST_POS);
    // Only the terminating beat needs room in the frame register
    assign rx_ready  = !last_byte || !frame_valid_reg || frame_ready;
    assign rx_beat   = rx_valid && rx_ready;

    always_comb
    begin
        pos_next = pos_reg;
        if (rx_beat)
        begin
            pos_next = last_byte ? '0 : pos_reg + 1'b1;
        end
        frame_valid_next = frame_valid_reg;
        if (frame_ready)
        begin
            frame_valid_next = 1'b0;
        end
        if (rx_beat && last_byte)
        begin
            frame_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            frame_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg         <= pos_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    // Header bytes, each written at its own position
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < HDR_BYTES; i++)
        begin
            if (rx_beat && (pos_reg == POS_W'(i)))
            begin
                hdr_reg[i] <= rx_byte;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_beat && last_byte)
        begin
            frame_reg.letter  <= hdr_reg[0];
            frame_reg.addr    <= hdr_reg[1];
            frame_reg.pulse   <= {hdr_reg[2], hdr_reg[3]};
            frame_reg.term_ok <= (rx_byte == CHAR_CR);
        end
    end

    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

endmodule

/* hw/rtl/pcfd_cmd_decode.sv */
// ----------------------------------------------------------------------------
// pcfd_cmd_decode
// Command decode of a completed frame into the result register.
// ----------------------------------------------------------------------------
module pcfd_cmd_decode
    import pcfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        frame_valid,
    output logic        frame_ready,
    input  frame_t      frame,
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  status,
    output logic [2:0]  write_target,
    output logic [15:0] write_value,
    output logic [7:0]  command_letter
);

    logic        res_valid_reg, res_valid_next;
    status_t     status_reg, status_next;
    logic [2:0]  target_reg, target_next;
    logic [15:0] value_reg, value_next;
    logic [7:0]  letter_reg;
    logic        noop;
    logic        load;

    always_comb
    begin
        unique case (frame.letter)
            CMD_P, CMD_U, CMD_D, CMD_R, CMD_V, CMD_G,
            CMD_H, CMD_K, CMD_E, CMD_F, CMD_O: noop = 1'b1;
            default:                           noop = 1'b0;
        endcase
    end

    always_comb
    begin
        status_next = STATUS_OK;
        target_next = TARGET_NONE;
        value_next  = '0;
        priority if (!frame.term_ok)
        begin
            status_next = STATUS_FRAMING;
        end
        else if (frame.letter == CMD_BIMORPH)
        begin
            if (frame.addr >= BIMORPH_ADDR_FIRST && frame.addr <= BIMORPH_ADDR_LAST)
            begin
                target_next = frame.addr[2:0];
                value_next  = frame.pulse;
            end
        end
        else if (frame.letter == CMD_MIRROR)
        begin
            target_next = TARGET_MIRROR;
            value_next  = frame.pulse;
        end
        else if (frame.letter == CMD_LASER)
        begin
            target_next = TARGET_LASER;
            value_next  = frame.pulse;
        end
        else
        begin
            if (!noop)
            begin
                status_next = STATUS_UNKNOWN;
            end
        end
    end

    assign frame_ready = !res_valid_reg || res_ready;
    assign load        = frame_valid && frame_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg <= status_next;
            target_reg <= target_next;
            value_reg  <= value_next;
            letter_reg <= frame.letter;
        end
    end

    assign res_valid      = res_valid_reg;
    assign status         = status_reg;
    assign write_target   = target_reg;
    assign write_value    = value_reg;
    assign command_letter = letter_reg;

endmodule

/* hw/rtl/pwm_command_frame_decoder.sv */
// ----------------------------------------------------------------------------
// pwm_command_frame_decoder
// Groups received bytes into 8-byte command frames and decodes PWM writes.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle, sustained, with the result side ready.
// Result path: the terminating (eighth) byte beat fills the frame register,
//   whose frame is then decoded into the result register.
// Reset (rst_n, async, active low): byte position to 0, no frame or result
//   pending. Header byte store is not reset; every frame rewrites it.
// ----------------------------------------------------------------------------
module pwm_command_frame_decoder
    import pcfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // received byte beats
    input  logic        rx_valid,
    output logic        rx_ready,
    input  logic [7:0]  rx_byte,
    // one result beat per completed frame
    output logic        res_valid,
    input  logic        res_ready,
    output logic [1:0]  status,
    output logic [2:0]  write_target,
    output logic [15:0] write_value,
    output logic [7:0]  command_letter
);

    // Completed frame, between capture and decode
    logic   frame_valid;
    logic   frame_ready;
    frame_t frame;

    // Position counter and header capture. Bytes 0..3 go to the header
    // store; bytes 4..6 are dropped; the eighth beat copies the header and
    // the terminator check into the frame register, so the next frame may
    // start at once while this one waits for decode.
    pcfd_frame_capture u_capture
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_valid    (rx_valid),
        .rx_ready    (rx_ready),
        .rx_byte     (rx_byte),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    // Letter and address decode into the result register. A missing
    // carriage return takes priority over any command decode.
    pcfd_cmd_decode u_decode
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .frame_valid    (frame_valid),
        .frame_ready    (frame_ready),
        .frame          (frame),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .status         (status),
        .write_target   (write_target),
        .write_value    (write_value),
        .command_letter (command_letter)
    );

endmodule

/* test/pcfd_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pcfd_result_checker
// Watches the byte and result channels of the PWM command frame decoder,
// rebuilds each 8-byte frame, predicts its result and compares every result
// beat field by field against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pcfd_result_checker
    import pcfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        rx_valid,
    input  logic        rx_ready,
    input  logic [7:0]  rx_byte,
    input  logic        res_valid,
    input  logic        res_ready,
    input  logic [1:0]  status,
    input  logic [2:0]  write_target,
    input  logic [15:0] write_value,
    input  logic [7:0]  command_letter,
    output int          fail_count,
    output int          results_due
);

    typedef struct packed {
        status_t     status;
        logic [2:0]  target;
        logic [15:0] value;
        logic [7:0]  letter;
    } frame_result_t;

    frame_result_t     due_q[$];
    logic [7:0]        hdr [HDR_BYTES];
    logic [POS_W-1:0]  pos;
    int                fails = 0;

    function automatic logic is_noop(input logic [7:0] c);
        case (c)
            CMD_P, CMD_U, CMD_D, CMD_R, CMD_V, CMD_G,
            CMD_H, CMD_K, CMD_E, CMD_F, CMD_O: return 1'b1;
            default:                           return 1'b0;
        endcase
    endfunction

    // Result of the frame held in hdr, closed by terminator byte term
    function automatic frame_result_t decode_frame(input logic [7:0] term);
        frame_result_t r;
        r.status = STATUS_OK;
        r.target = TARGET_NONE;
        r.value  = '0;
        r.letter = hdr[0];
        if (term != CHAR_CR)
            r.status = STATUS_FRAMING;
        else if (hdr[0] == CMD_BIMORPH)
        begin
            if (hdr[1] >= BIMORPH_ADDR_FIRST && hdr[1] <= BIMORPH_ADDR_LAST)
            begin
                r.target = hdr[1][2:0];
                r.value  = {hdr[2], hdr[3]};
            end
        end
        else if (hdr[0] == CMD_MIRROR)
        begin
            r.target = TARGET_MIRROR;
            r.value  = {hdr[2], hdr[3]};
        end
        else if (hdr[0] == CMD_LASER)
        begin
            r.target = TARGET_LASER;
            r.value  = {hdr[2], hdr[3]};
        end
        else if (!is_noop(hdr[0]))
            r.status = STATUS_UNKNOWN;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [15:0] want,
                               input logic [15:0] seen);
        if (seen !== want)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        frame_result_t want;
        if (!rst_n)
        begin
            pos = '0;
            due_q.delete();
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (due_q.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result beat, actual status %0h target %0h",
                             $time, status, write_target);
                    $display("%0t: unexpected result beat, actual value %0h letter %0h",
                             $time, write_value, command_letter);
                end
                else
                begin
                    want = due_q.pop_front();
                    check_field("status", 16'(want.status), 16'(status));
                    check_field("write_target", 16'(want.target), 16'(write_target));
                    check_field("write_value", want.value, write_value);
                    check_field("command_letter", 16'(want.letter), 16'(command_letter));
                end
            end
            if (rx_valid && rx_ready)
            begin
                if (pos < HDR_BYTES)
                    hdr[pos[1:0]] = rx_byte;
                if (pos == FRAME_LEN - 1)
                begin
                    due_q.push_back(decode_frame(rx_byte));
                    pos = '0;
                end
                else
                    pos = pos + 1'b1;
            end
        end
        fail_count  <= fails;
        results_due <= due_q.size();
    end

endmodule

/* test/pwm_command_frame_decoder_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pwm_command_frame_decoder_test
// Drives 8-byte command frames into the decoder: a few hand-picked frames at
// the field extremes, then about a hundred random frames weighted towards the
// real commands, with random gaps on both channels, a gap-free stretch and one
// long result back-pressure hold. Prediction and checking sit in the checker.
// ----------------------------------------------------------------------------
module pwm_command_frame_decoder_test
    import pcfd_pkg::*;
();

    localparam int RANDOM_FRAMES = 100;
    localparam int HOLD_CYCLES   = 300;   // long result-side hold-off
    localparam int IDLE_LIMIT    = 2000;  // cycles with no beat on either side
    localparam int DRAIN_CYCLES  = 20;    // trailing wait

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        rx_valid  = 1'b0;
    logic        rx_ready;
    logic [7:0]  rx_byte   = 8'h00;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [1:0]  status;
    logic [2:0]  write_target;
    logic [15:0] write_value;
    logic [7:0]  command_letter;

    int   fail_count;
    int   results_due;
    int   idle_cycles = 0;

    // Stimulus modes, shared between the sender and receiver processes
    logic hold_req  = 1'b0;   // ask the receiver for the long hold-off
    logic hold_done = 1'b0;   // receiver has finished it
    logic steady    = 1'b0;   // both sides run flat out, no gaps

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    pwm_command_frame_decoder u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_valid),
        .rx_ready       (rx_ready),
        .rx_byte        (rx_byte),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .status         (status),
        .write_target   (write_target),
        .write_value    (write_value),
        .command_letter (command_letter)
    );

    pcfd_result_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_valid),
        .rx_ready       (rx_ready),
        .rx_byte        (rx_byte),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .status         (status),
        .write_target   (write_target),
        .write_value    (write_value),
        .command_letter (command_letter),
        .fail_count     (fail_count),
        .results_due    (results_due)
    );

    // Gap length for either side: mostly none, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] noop_letter(input int idx);
        case (idx)
            0:       return CMD_P;
            1:       return CMD_U;
            2:       return CMD_D;
            3:       return CMD_R;
            4:       return CMD_V;
            5:       return CMD_G;
            6:       return CMD_H;
            7:       return CMD_K;
            8:       return CMD_E;
            9:       return CMD_F;
            default: return CMD_O;
        endcase
    endfunction

    // Command letter: real writes favoured, no-ops common, any byte now and then
    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30)
            return CMD_BIMORPH;
        if (r < 42)
            return CMD_MIRROR;
        if (r < 54)
            return CMD_LASER;
        if (r < 80)
            return noop_letter($urandom_range(0, 10));
        return 8'($urandom);
    endfunction

    // Mostly a valid bimorph channel, otherwise zero or anything at all
    function automatic logic [7:0] pick_addr();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 8'h00;
        if (r < 25)
            return 8'($urandom);
        return 8'($urandom_range(BIMORPH_ADDR_FIRST, BIMORPH_ADDR_LAST));
    endfunction

    function automatic logic [15:0] pick_pulse();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom);
    endfunction

    // One byte beat; valid stays up straight into the next byte when no gap
    task automatic send_byte(input logic [7:0] b);
        int gap;
        rx_valid <= 1'b1;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (!(rx_valid && rx_ready));
        gap = (steady || (hold_req && !hold_done)) ? 0 : idle_len();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            rx_byte  <= 8'($urandom);   // junk on the bus while idle
            repeat (gap) @(posedge clk);
        end
    endtask

    // Letter, address, pulse big-endian, three ignored bytes, terminator
    task automatic send_frame(input logic [7:0] letter, input logic [7:0] addr,
                              input logic [15:0] pulse, input logic [7:0] term);
        send_byte(letter);
        send_byte(addr);
        send_byte(pulse[15:8]);
        send_byte(pulse[7:0]);
        repeat (3) send_byte(8'($urandom));
        send_byte(term);
    endtask

    // Receiver: random stalls, plus the one long hold-off on request
    initial
    begin
        int stall;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req && !hold_done)
            begin
                res_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done <= 1'b1;
                res_ready <= 1'b1;
            end
            else
            begin
                stall = steady ? 0 : idle_len();
                if (stall == 0)
                    res_ready <= 1'b1;
                else
                begin
                    res_ready <= 1'b0;
                    repeat (stall - 1) @(posedge clk);
                end
            end
        end
    end

    // Watchdog: too long without a beat on either channel
    always @(posedge clk)
    begin
        if ((rx_valid && rx_ready) || (res_valid && res_ready))
            idle_cycles <= 0;
        else if (rst_n)
        begin
            if (idle_cycles == IDLE_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
                $display("FAIL");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: bimorph at the top channel and full-scale pulse, bimorph
        // with an out-of-range address and zero pulse, and an all-ones frame
        // with a bad terminator
        send_frame(CMD_BIMORPH, BIMORPH_ADDR_LAST, 16'hFFFF, CHAR_CR);
        send_frame(CMD_BIMORPH, 8'h00, 16'h0000, CHAR_CR);
        send_frame(8'hFF, 8'hFF, 16'hFFFF, 8'h00);

        // Random frames; about one in seven has a broken terminator
        for (int n = 0; n < RANDOM_FRAMES; n++)
        begin
            logic [7:0] term;
            if (n == 30)
                hold_req <= 1'b1;
            steady <= (n >= 60 && n < 75);
            term = ($urandom_range(0, 99) < 85) ? CHAR_CR : 8'($urandom);
            send_frame(pick_letter(), pick_addr(), pick_pulse(), term);
        end
        rx_valid <= 1'b0;
        steady   <= 1'b0;

        // The checker's count is registered, so it trails its queue
        @(posedge clk);
        while (results_due != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && results_due == 0)
            $display("PASS");
        else
        begin
            if (results_due != 0)
                $display("%0t: %0d frame results never arrived", $time, results_due);
            $display("FAIL");
        end
        $finish;
    end

endmodule

/* files.f */
hw/rtl/pcfd_pkg.sv
hw/rtl/pcfd_frame_capture.sv
hw/rtl/pcfd_cmd_decode.sv
hw/rtl/pwm_command_frame_decoder.sv
test/pcfd_result_checker.sv
test/pwm_command_frame_decoder_test.sv
